// ===== hdl/wbrs_pkg.sv =====
// Shared types, codes and sizes of the write-barrier remembered set.
`default_nettype none
package wbrs_pkg;

  localparam int ADDR_W      = 48;
  localparam int HASH_SLOTS  = 4096;
  localparam int HASH_AW     = $clog2(HASH_SLOTS);
  localparam int BUF_DEPTH   = 4096;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int PROBE_LIMIT = 8;
  localparam int PROBE_W     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int CNT_W       = 13;
  localparam int TALLY_W     = 32;
  localparam int IDX_W       = 12;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 64;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(24 * 1024 / 8);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(BUF_DEPTH);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_REGION_BEGIN = 2'd0;
  localparam logic [1:0] REG_REGION_END   = 2'd1;
  localparam logic [1:0] REG_SET_CAPACITY = 2'd2;

  // Command codes.
  localparam logic [1:0] CMD_BARRIER = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_VALUE_OUT = 3'd0;
  localparam logic [2:0] ST_SLOT_IN   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_ADDED     = 3'd3;
  localparam logic [2:0] ST_UNHASHED  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;
  localparam logic [2:0] ST_READ      = 3'd7;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] slot_addr;
    logic [ADDR_W-1:0] value_addr;
    logic [IDX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ADDR_W-1:0]  entry_addr;
    logic [IDX_W-1:0]   entry_index;
    logic [CNT_W-1:0]   set_count;
    logic [TALLY_W-1:0] barrier_count;
    logic [TALLY_W-1:0] duplicate_count;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] region_begin;
    logic [ADDR_W-1:0] region_end;
    logic [CNT_W-1:0]  set_capacity;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       probe_init;
    logic       probe_next;
    logic       hash_rd;
    logic       hash_ins;
    logic       sweep_we;
    logic       buf_rd;
    logic       append;
    logic       emit;
    logic [2:0] status;
    logic       inc_passed;
    logic       inc_dup;
    logic       clear_count;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] command;
    logic       value_out;
    logic       slot_in;
    logic       full;
    logic       hit;
    logic       empty;
    logic       last_probe;
    logic       sweep_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/wbrs_cfg.sv =====
// APB-style register bank holding the region bounds and the set capacity.
`default_nettype none
module wbrs_cfg
  import wbrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr;
  logic [1:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_begin <= '0;
      cfg.region_end   <= '0;
      cfg.set_capacity <= CAP_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_REGION_BEGIN: cfg.region_begin <= pwdata[ADDR_W-1:0];
        REG_REGION_END:   cfg.region_end   <= pwdata[ADDR_W-1:0];
        REG_SET_CAPACITY: cfg.set_capacity <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_REGION_BEGIN: prdata = CFG_DW'(cfg.region_begin);
      REG_REGION_END:   prdata = CFG_DW'(cfg.region_end);
      REG_SET_CAPACITY: prdata = CFG_DW'(cfg.set_capacity);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/wbrs_dp.sv =====
// Datapath: item registers, region filters, hash table, slot buffer, counters, result.
`default_nettype none
module wbrs_dp
  import wbrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire item_t     item,
  input  wire cfg_t      cfg,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     st,
  output result_t        result,
  output logic           done
);

  localparam int HASH_W = ADDR_W + 1;

  logic [HASH_W-1:0] hash_mem [HASH_SLOTS];
  logic [ADDR_W-1:0] buf_mem  [BUF_DEPTH];

  item_t              cur;
  logic [HASH_W-1:0]  hash_q;
  logic [ADDR_W-1:0]  buf_q;
  logic [HASH_AW-1:0] probe_idx;
  logic [PROBE_W-1:0] probe_cnt;
  logic [HASH_AW-1:0] sweep_idx;
  logic [CNT_W-1:0]   entry_total;
  logic [TALLY_W-1:0] passed_total;
  logic [TALLY_W-1:0] dup_total;

  logic [CNT_W-1:0]   entry_total_next;
  logic [TALLY_W-1:0] passed_total_next;
  logic [TALLY_W-1:0] dup_total_next;
  logic [CNT_W-1:0]   eff_cap;
  logic               hash_we;
  logic [HASH_AW-1:0] hash_waddr;
  logic [HASH_W-1:0]  hash_wdata;
  logic [ADDR_W-1:0]  res_addr;
  logic [IDX_W-1:0]   res_index;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
  end

  // Region filters and the capacity check.
  assign eff_cap = (cfg.set_capacity > CAP_MAX) ? CAP_MAX : cfg.set_capacity;

  always_comb begin
    st.command    = cur.command;
    st.value_out  = (cur.value_addr < cfg.region_begin) ||
                    (cur.value_addr >= cfg.region_end);
    st.slot_in    = (cur.slot_addr >= cfg.region_begin) &&
                    (cur.slot_addr < cfg.region_end);
    st.full       = entry_total >= eff_cap;
    st.hit        = hash_q[ADDR_W] && (hash_q[ADDR_W-1:0] == cur.slot_addr);
    st.empty      = !hash_q[ADDR_W];
    st.last_probe = probe_cnt == PROBE_W'(PROBE_LIMIT - 1);
    st.sweep_last = sweep_idx == HASH_AW'(HASH_SLOTS - 1);
  end

  // Probe position walks linearly from the home entry and wraps with the table.
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      probe_idx <= cur.slot_addr[HASH_AW+2:3];
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      probe_idx <= probe_idx + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_we) begin
      sweep_idx <= sweep_idx + 1'b1;
    end
  end

  // Hash table: one entry per cycle, top bit marks a live entry.
  assign hash_we    = cmd.sweep_we || cmd.hash_ins;
  assign hash_waddr = cmd.sweep_we ? sweep_idx : probe_idx;
  assign hash_wdata = cmd.sweep_we ? '0 : {1'b1, cur.slot_addr};

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_waddr] <= hash_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_rd) begin
      hash_q <= hash_mem[probe_idx];
    end
  end

  // Slot buffer.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      buf_mem[entry_total[BUF_AW-1:0]] <= cur.slot_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_rd) begin
      buf_q <= buf_mem[cur.read_index[BUF_AW-1:0]];
    end
  end

  // Counters as they stand after this command.
  always_comb begin
    entry_total_next  = entry_total;
    passed_total_next = passed_total;
    dup_total_next    = dup_total;
    if (cmd.clear_count) begin
      entry_total_next = '0;
    end else if (cmd.append) begin
      entry_total_next = entry_total + 1'b1;
    end
    if (cmd.inc_passed) begin
      passed_total_next = passed_total + 1'b1;
    end
    if (cmd.inc_dup) begin
      dup_total_next = dup_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total  <= '0;
      passed_total <= '0;
      dup_total    <= '0;
    end else begin
      entry_total  <= entry_total_next;
      passed_total <= passed_total_next;
      dup_total    <= dup_total_next;
    end
  end

  always_comb begin
    res_addr  = '0;
    res_index = '0;
    unique case (cmd.status)
      ST_DUPLICATE, ST_OVERFLOW: res_addr = cur.slot_addr;
      ST_ADDED, ST_UNHASHED: begin
        res_addr  = cur.slot_addr;
        res_index = IDX_W'(entry_total);
      end
      ST_READ: begin
        // Entries at or beyond the count were never written for this set.
        res_addr  = (CNT_W'(cur.read_index) < entry_total) ? buf_q : '0;
        res_index = cur.read_index;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status          <= cmd.status;
      result.entry_addr      <= res_addr;
      result.entry_index     <= res_index;
      result.set_count       <= entry_total_next;
      result.barrier_count   <= passed_total_next;
      result.duplicate_count <= dup_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wbrs_ctrl.sv =====
// Controller: sequences filtering, hash probes, table sweeps and buffer reads.
`default_nettype none
module wbrs_ctrl
  import wbrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd,
  output logic            busy
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_PREAD  = 3'd3;
  localparam logic [2:0] S_PCMP   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_RDOUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.status = ST_VALUE_OUT;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.sweep_we = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (st.command)
          CMD_BARRIER: begin
            priority if (st.value_out) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_VALUE_OUT;
            end else if (st.slot_in) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_SLOT_IN;
            end else if (st.full) begin
              cmd.emit       = 1'b1;
              cmd.status     = ST_OVERFLOW;
              cmd.inc_passed = 1'b1;
            end else begin
              cmd.probe_init = 1'b1;
              state_next     = S_PREAD;
            end
          end
          CMD_CLEAR: state_next = S_CLEAR;
          CMD_READ: begin
            cmd.buf_rd = 1'b1;
            state_next = S_RDOUT;
          end
          default: ;
        endcase
      end
      S_PREAD: begin
        cmd.hash_rd = 1'b1;
        state_next  = S_PCMP;
      end
      S_PCMP: begin
        state_next = S_IDLE;
        priority if (st.hit) begin
          cmd.emit       = 1'b1;
          cmd.status     = ST_DUPLICATE;
          cmd.inc_passed = 1'b1;
          cmd.inc_dup    = 1'b1;
        end else if (st.empty) begin
          cmd.emit       = 1'b1;
          cmd.status     = ST_ADDED;
          cmd.inc_passed = 1'b1;
          cmd.hash_ins   = 1'b1;
          cmd.append     = 1'b1;
        end else if (st.last_probe) begin
          // Every probe met another slot: keep it in the buffer only.
          cmd.emit       = 1'b1;
          cmd.status     = ST_UNHASHED;
          cmd.inc_passed = 1'b1;
          cmd.append     = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_PREAD;
        end
      end
      S_CLEAR: begin
        cmd.sweep_we = 1'b1;
        if (st.sweep_last) begin
          cmd.emit        = 1'b1;
          cmd.status      = ST_CLEARED;
          cmd.clear_count = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RDOUT: begin
        cmd.emit   = 1'b1;
        cmd.status = ST_READ;
        state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/write_barrier_remembered_set.sv =====
// Top level of the write-barrier filter with its deduplicating remembered set.
//
//   channel   signals                          beat taken when
//   ------    -------------------------------  ----------------------------
//   command   start, busy, item                start high and busy low
//   result    done, result                     done high (one cycle, no stall)
//   config    psel, penable, pwrite, paddr,    psel, penable, pwrite, pready
//             pwdata, prdata, pready
//
// A filtered or overflowing barrier is decided in the decode state; a probed
// barrier runs a table read state and a compare state for each of its k probes
// (1 to 8). A read fetches its buffer entry in the decode state, then emits.
// A clear sweeps the table one entry a cycle.
// After reset the same sweep runs with busy high.
// Results cannot be stalled; busy drops in the cycle a result is shown.
`default_nettype none
module write_barrier_remembered_set
  import wbrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire item_t             item,
  output logic                   done,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  wbrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  wbrs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .cmd    (cmd),
    .st     (st),
    .result (result),
    .done   (done)
  );

endmodule
`default_nettype wire

// ===== hdl/wbrs_checker.sv =====
// Port-level checks of the remembered set, bound to the top level.
`default_nettype none
module wbrs_checker
  import wbrs_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  logic [IDX_W-1:0] last_pos;

  assign last_pos = IDX_W'(result.set_count - 1'b1);

  // Each command yields at most one result, so strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after taking a command");

  a_append_position: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_ADDED || result.status == ST_UNHASHED))
      |-> (result.entry_index == last_pos) && (result.set_count != '0))
    else $error("appended slot position does not match the set count");

  a_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_VALUE_OUT || result.status == ST_SLOT_IN ||
              result.status == ST_CLEARED))
      |-> (result.entry_addr == '0) && (result.entry_index == '0))
    else $error("filtered or clear result carries an address");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_CLEARED) |-> (result.set_count == '0))
    else $error("clear left a nonzero set count");

endmodule

bind write_barrier_remembered_set wbrs_checker u_wbrs_checker (.*);
`default_nettype wire

// ===== tb/write_barrier_remembered_set_test.sv =====
// Self-checking testbench of the write-barrier filter and its remembered set.
`timescale 1ns / 100ps
module write_barrier_remembered_set_test;
  import wbrs_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         MAX_REPORTS   = 10;
  localparam int         PHASES        = 5;

  typedef struct {
    logic    reconfigure;
    cfg_t    cfg;
    item_t   stim;
    logic    typed;
    result_t want;
  } plan_row_t;

  typedef struct {
    cfg_t              cfg;
    int                items;
    int                idle_pct;
    logic [ADDR_W-1:0] slot_base;
  } phase_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  item_t             item;
  logic              done;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  write_barrier_remembered_set DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the remembered set and its settings.
  cfg_t               cfg_now;
  logic [ADDR_W-1:0]  hash_addr [HASH_SLOTS];
  bit                 hash_used [HASH_SLOTS];
  logic [ADDR_W-1:0]  slot_log [BUF_DEPTH];
  logic [CNT_W-1:0]   log_fill;
  logic [TALLY_W-1:0] passed_tally;
  logic [TALLY_W-1:0] dup_tally;

  result_t pending_outcomes[$];
  int      mismatches;
  int      commands_sent;
  int      cfg_writes;
  int      status_seen [8];

  // Slot generation: a narrow window of hash homes so that probes collide.
  logic [ADDR_W-1:0] slot_base;
  int                home_base;
  logic [ADDR_W-1:0] recent_slots [16];
  int                recent_wr;

  plan_row_t plan[$];
  phase_t    phases [PHASES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Run stopped: results still outstanding at the time limit");
    $display("*** FAILED ***");
    $finish;
  end

  task automatic log_mismatch(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("Mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) log_mismatch(what, want, got);
  endtask

  // Works out the outcome of one accepted command and advances the shadow state.
  task automatic predict_outcome(input item_t it, output bit produced, output result_t r);
    logic [ADDR_W-1:0]  s;
    logic [ADDR_W-1:0]  v;
    logic [HASH_AW-1:0] home;
    logic [HASH_AW-1:0] probe_ix;
    logic [CNT_W-1:0]   cap;
    bit                 settled;
    bit                 append;
    s = it.slot_addr;
    v = it.value_addr;
    r = '0;
    produced = 1'b1;
    append = 1'b0;
    case (it.command)
      CMD_BARRIER: begin
        if (v < cfg_now.region_begin || v >= cfg_now.region_end) begin
          r.status = ST_VALUE_OUT;
        end else if (s >= cfg_now.region_begin && s < cfg_now.region_end) begin
          r.status = ST_SLOT_IN;
        end else begin
          passed_tally++;
          r.entry_addr = s;
          cap = (cfg_now.set_capacity > CAP_MAX) ? CAP_MAX : cfg_now.set_capacity;
          if (log_fill >= cap) begin
            r.status = ST_OVERFLOW;
          end else begin
            home = s[HASH_AW+2:3];
            settled = 1'b0;
            for (int p = 0; p < PROBE_LIMIT && !settled; p++) begin
              probe_ix = home + HASH_AW'(p);
              if (hash_used[probe_ix] && hash_addr[probe_ix] == s) begin
                dup_tally++;
                r.status = ST_DUPLICATE;
                settled = 1'b1;
              end else if (!hash_used[probe_ix]) begin
                hash_used[probe_ix] = 1'b1;
                hash_addr[probe_ix] = s;
                r.status = ST_ADDED;
                append = 1'b1;
                settled = 1'b1;
              end
            end
            // Every probe hit some other slot: the slot goes in unhashed.
            if (!settled) begin
              r.status = ST_UNHASHED;
              append = 1'b1;
            end
            if (append) begin
              r.entry_index = log_fill[IDX_W-1:0];
              slot_log[log_fill[IDX_W-1:0]] = s;
              log_fill++;
            end
          end
        end
      end
      CMD_CLEAR: begin
        log_fill = '0;
        foreach (hash_used[i]) hash_used[i] = 1'b0;
        r.status = ST_CLEARED;
      end
      CMD_READ: begin
        r.status = ST_READ;
        r.entry_index = it.read_index;
        if (CNT_W'(it.read_index) < log_fill) r.entry_addr = slot_log[it.read_index];
      end
      default: produced = 1'b0;
    endcase
    r.set_count = log_fill;
    r.barrier_count = passed_tally;
    r.duplicate_count = dup_tally;
  endtask

  always @(posedge clk) begin : check_outcome
    result_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        log_mismatch("result with nothing outstanding", '0, 64'(result.status));
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("status", 64'(want.status), 64'(result.status));
        compare_field("entry_addr", 64'(want.entry_addr), 64'(result.entry_addr));
        compare_field("entry_index", 64'(want.entry_index), 64'(result.entry_index));
        compare_field("set_count", 64'(want.set_count), 64'(result.set_count));
        compare_field("barrier_count", 64'(want.barrier_count),
                      64'(result.barrier_count));
        compare_field("duplicate_count", 64'(want.duplicate_count),
                      64'(result.duplicate_count));
        status_seen[result.status]++;
      end
    end
  end

  // Holds the command on the port until the block takes the beat.
  task automatic send(input item_t it, output bit produced, output result_t pred);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_outcome(it, produced, pred);
    if (produced) commands_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write followed by a read back of the same register.
  task automatic cfg_access(input logic [1:0] index, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({index, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    compare_field("register read back", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_region_cfg(input cfg_t c);
    cfg_access(REG_REGION_BEGIN, CFG_DW'(c.region_begin));
    cfg_access(REG_REGION_END, CFG_DW'(c.region_end));
    cfg_access(REG_SET_CAPACITY, CFG_DW'(c.set_capacity));
    cfg_now = c;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    return r64[ADDR_W-1:0];
  endfunction

  function automatic item_t mk_barrier(input logic [ADDR_W-1:0] s,
                                       input logic [ADDR_W-1:0] v);
    item_t it;
    it = '0;
    it.command = CMD_BARRIER;
    it.slot_addr = s;
    it.value_addr = v;
    return it;
  endfunction

  function automatic item_t mk_read(input logic [IDX_W-1:0] ix);
    item_t it;
    it = '0;
    it.command = CMD_READ;
    it.read_index = ix;
    return it;
  endfunction

  function automatic result_t res(input logic [2:0] st, input logic [ADDR_W-1:0] a,
                                  input logic [IDX_W-1:0] ix, input logic [CNT_W-1:0] n,
                                  input logic [TALLY_W-1:0] b,
                                  input logic [TALLY_W-1:0] d);
    return '{st, a, ix, n, b, d};
  endfunction

  function automatic logic [ADDR_W-1:0] fresh_slot();
    logic [ADDR_W-1:0] s;
    s = slot_base | (ADDR_W'($urandom_range(0, 11)) << 15)
      | (ADDR_W'((home_base + $urandom_range(0, 11)) % HASH_SLOTS) << 3)
      | ADDR_W'($urandom_range(0, 7));
    recent_slots[recent_wr] = s;
    recent_wr = (recent_wr + 1) % 16;
    return s;
  endfunction

  // A young value, its bounds picked now and then; any address if the region is empty.
  function automatic logic [ADDR_W-1:0] young_value();
    logic [63:0] span;
    logic [63:0] pick;
    if (cfg_now.region_end <= cfg_now.region_begin) return rand_addr();
    span = 64'(cfg_now.region_end) - 64'(cfg_now.region_begin);
    case ($urandom_range(0, 9))
      0: return cfg_now.region_begin;
      1: return cfg_now.region_end - 1'b1;
      default: begin
        pick = 64'(cfg_now.region_begin) + ({$urandom, $urandom} % span);
        return pick[ADDR_W-1:0];
      end
    endcase
  endfunction

  // Mostly well-formed barriers on colliding slots; the rest reads, clears and noise.
  function automatic item_t gen_item();
    item_t it;
    int    roll;
    it.command = 2'($urandom_range(0, 3));
    it.slot_addr = rand_addr();
    it.value_addr = rand_addr();
    it.read_index = IDX_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 58) begin
      it.command = CMD_BARRIER;
      it.slot_addr = fresh_slot();
      it.value_addr = young_value();
    end else if (roll < 68) begin
      it.command = CMD_BARRIER;
      it.slot_addr = recent_slots[$urandom_range(0, 15)];
      it.value_addr = young_value();
    end else if (roll < 74) begin
      it.command = CMD_BARRIER;
    end else if (roll < 79) begin
      it.command = CMD_BARRIER;
      it.slot_addr = young_value();
      it.value_addr = young_value();
    end else if (roll < 92) begin
      it.command = CMD_READ;
      if (roll < 87 && log_fill != 0)
        it.read_index = IDX_W'($urandom_range(0, int'(log_fill) - 1));
    end else if (roll < 94) begin
      it.command = CMD_CLEAR;
    end else if (roll < 96) begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  initial begin : stimulus
    cfg_t    keep;
    cfg_t    small_set;
    cfg_t    wide_set;
    item_t   it;
    result_t pred;
    bit      produced;
    int      n;

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_now = '{'0, '0, CAP_RESET};
    foreach (hash_used[i]) hash_used[i] = 1'b0;
    log_fill = '0;
    passed_tally = '0;
    dup_tally = '0;
    mismatches = 0;
    commands_sent = 0;
    cfg_writes = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (recent_slots[i]) recent_slots[i] = '0;
    recent_wr = 0;
    keep = '0;
    small_set = '{48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, CNT_W'(4)};
    wide_set = '{48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, CAP_MAX};

    // Settings after reset leave the young region empty.
    plan.push_back('{1'b0, keep, mk_barrier('0, '0), 1'b1,
                     res(ST_VALUE_OUT, '0, '0, '0, '0, '0)});
    plan.push_back('{1'b0, keep, mk_read('0), 1'b1, res(ST_READ, '0, '0, '0, '0, '0)});
    plan.push_back('{1'b0, keep, mk_read('1), 1'b1, res(ST_READ, '0, '1, '0, '0, '0)});
    plan.push_back('{1'b0, keep, '{CMD_UNUSED, '1, '1, '1}, 1'b0, '0});
    // Slot address zero is a real slot; region bounds are inclusive then exclusive.
    plan.push_back('{1'b1, small_set, mk_barrier('0, 48'h8000_0000_0000), 1'b1,
                     res(ST_ADDED, '0, '0, 13'd1, 32'd1, 32'd0)});
    plan.push_back('{1'b0, keep, mk_barrier('0, 48'hFFFF_FFFF_FFFE), 1'b1,
                     res(ST_DUPLICATE, '0, '0, 13'd1, 32'd2, 32'd1)});
    plan.push_back('{1'b0, keep, mk_barrier('0, 48'hFFFF_FFFF_FFFF), 1'b1,
                     res(ST_VALUE_OUT, '0, '0, 13'd1, 32'd2, 32'd1)});
    plan.push_back('{1'b0, keep, mk_barrier('0, 48'h7FFF_FFFF_FFFF), 1'b1,
                     res(ST_VALUE_OUT, '0, '0, 13'd1, 32'd2, 32'd1)});
    plan.push_back('{1'b0, keep, mk_barrier(48'h8000_0000_0000, 48'h8000_0000_0000), 1'b1,
                     res(ST_SLOT_IN, '0, '0, 13'd1, 32'd2, 32'd1)});
    // Collisions on the first and last home, the second one wrapping round the table.
    plan.push_back('{1'b0, keep, mk_barrier(48'h8000, 48'hC000_0000_0000), 1'b0, '0});
    plan.push_back('{1'b0, keep, mk_barrier(48'h7FFF_FFFF_FFF8, 48'hC000_0000_0000),
                     1'b0, '0});
    plan.push_back('{1'b0, keep, mk_barrier(48'h7FFF_FFFF_7FF8, 48'hC000_0000_0000),
                     1'b0, '0});
    plan.push_back('{1'b0, keep, mk_barrier(48'h1234, 48'hC000_0000_0000), 1'b1,
                     res(ST_OVERFLOW, 48'h1234, '0, 13'd4, 32'd6, 32'd1)});
    plan.push_back('{1'b0, keep, mk_read(12'd3), 1'b0, '0});
    plan.push_back('{1'b0, keep, mk_read(12'd4), 1'b1,
                     res(ST_READ, '0, 12'd4, 13'd4, 32'd6, 32'd1)});
    plan.push_back('{1'b0, keep, '{CMD_CLEAR, '0, '0, '0}, 1'b1,
                     res(ST_CLEARED, '0, '0, '0, 32'd6, 32'd1)});
    // Nine slots sharing one home exhaust the probes; the ninth goes in unhashed twice.
    for (int k = 1; k <= 10; k++)
      plan.push_back('{k == 1, wide_set,
                       mk_barrier(ADDR_W'((k > 9 ? 9 : k)) << 15, 48'hA000_0000_0000),
                       1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].reconfigure) begin
        settle();
        load_region_cfg(plan[i].cfg);
      end
      send(plan[i].stim, produced, pred);
      if (produced) pending_outcomes.push_back(plan[i].typed ? plan[i].want : pred);
    end

    phases[0] = '{'{48'h1000_0000_0000, 48'h2000_0000_0000, CAP_RESET}, 240, 0,
                  48'h3000_0000_0000};
    phases[1] = '{'{48'h0, 48'h0001_0000_0000, CNT_W'(40)}, 200, 83, 48'h7000_0000_0000};
    phases[2] = '{'{48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF, '1}, 160, 17, 48'h0};
    phases[3] = '{'{48'h100, 48'h10000, '0}, 40, 17, 48'h5000_0000_0000};
    // Inverted region: nothing can ever be young.
    phases[4] = '{'{48'hFFFF_FFFF_FFFF, 48'h0, CAP_MAX}, 40, 0, 48'h0};

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_region_cfg(phases[ph].cfg);
      slot_base = phases[ph].slot_base;
      home_base = $urandom_range(0, 1) ? HASH_SLOTS - 6 : $urandom_range(0, HASH_SLOTS - 1);
      n = 0;
      while (n < phases[ph].items) begin
        it = gen_item();
        send(it, produced, pred);
        if (produced) begin
          pending_outcomes.push_back(pred);
          n++;
        end
        if ($urandom_range(0, 99) == 0) begin
          settle();
        end else begin
          while ($urandom_range(0, 99) < phases[ph].idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
          end
        end
      end
    end

    settle();
    $display("Covered %0d commands over %0d register writes in %0d setting phases",
             commands_sent, cfg_writes, PHASES + 3);
    $write("Outcomes: %0d added, %0d unhashed, %0d duplicate, %0d overflow, ",
           status_seen[ST_ADDED], status_seen[ST_UNHASHED], status_seen[ST_DUPLICATE],
           status_seen[ST_OVERFLOW]);
    $display("%0d filtered, %0d cleared, %0d read",
             status_seen[ST_VALUE_OUT] + status_seen[ST_SLOT_IN],
             status_seen[ST_CLEARED], status_seen[ST_READ]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in all", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
